/* sv/steering_override_fault_supervisor_unit_macros.svh */
// assertion macros for the supervisor
`ifndef STEERING_OVERRIDE_FAULT_SUPERVISOR_UNIT_MACROS_SVH
`define STEERING_OVERRIDE_FAULT_SUPERVISOR_UNIT_MACROS_SVH

// same-cycle implication
`define SOFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("supervisor assertion failed");

// next-cycle implication
`define SOFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("supervisor assertion failed");

`endif

/* sv/sofs_pkg.sv */
package sofs_pkg;

   localparam int TORQUE_W = 8;
   localparam int CODE_W = 8;
   localparam int MODE_W = 2;
   localparam int FAULT_W = 4;
   localparam int TIME_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [1:0] {
      KIND_TICK      = 2'd0,
      KIND_TORQUE    = 2'd1,
      KIND_STATUS    = 2'd2,
      KIND_HEARTBEAT = 2'd3
   } kind_type;

   localparam logic [MODE_W-1:0] MODE_DISENGAGED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ARMED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FAULT = 2'd3;

   localparam int FLT_OVERRIDE = 0;
   localparam int FLT_UNIT = 1;
   localparam int FLT_HEARTBEAT = 2;
   localparam int FLT_STATUS = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPIKE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERSIST_TIME = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT_TIMEOUT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATUS_TIMEOUT = 2'd3;

   localparam logic [TORQUE_W-1:0] SPIKE_THRESHOLD_RESET = 8'd8;
   localparam logic [TIME_W-1:0] PERSIST_TIME_RESET = 16'd50;
   localparam logic [TIME_W-1:0] HEARTBEAT_TIMEOUT_RESET = 16'd100;
   localparam logic [TIME_W-1:0] STATUS_TIMEOUT_RESET = 16'd250;
   localparam logic [TORQUE_W-1:0] BASELINE_RESET = 8'd128;

   typedef struct packed {
      logic [TORQUE_W-1:0] spike_threshold;
      logic [TIME_W-1:0]   persist_time;
      logic [TIME_W-1:0]   heartbeat_timeout;
      logic [TIME_W-1:0]   status_timeout;
   } cfg_type;

   typedef struct packed {
      kind_type            kind;
      logic [TORQUE_W-1:0] torque_a;
      logic [TORQUE_W-1:0] torque_b;
      logic [CODE_W-1:0]   unit_code;
      logic [MODE_W-1:0]   requested_mode;
   } item_type;

   typedef struct packed {
      logic                spike_pending;
      logic [FAULT_W-1:0]  fault_mask;
      logic [MODE_W-1:0]   mode;
   } result_type;

endpackage

/* sv/sofs_cfg.sv */
module sofs_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [sofs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sofs_pkg::CSR_DATA_W-1:0]      csr_data,
   output sofs_pkg::cfg_type                    cfg
);
   import sofs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SPIKE_THRESHOLD:   cfg_in.spike_threshold = csr_data[TORQUE_W-1:0];
            CSR_PERSIST_TIME:      cfg_in.persist_time = csr_data[TIME_W-1:0];
            CSR_HEARTBEAT_TIMEOUT: cfg_in.heartbeat_timeout = csr_data[TIME_W-1:0];
            CSR_STATUS_TIMEOUT:    cfg_in.status_timeout = csr_data[TIME_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spike_threshold <= SPIKE_THRESHOLD_RESET;
         cfg_ff.persist_time <= PERSIST_TIME_RESET;
         cfg_ff.heartbeat_timeout <= HEARTBEAT_TIMEOUT_RESET;
         cfg_ff.status_timeout <= STATUS_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/sofs_eval.sv */
`include "steering_override_fault_supervisor_unit_macros.svh"

module sofs_eval #(
   parameter int AGE_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sofs_pkg::cfg_type    cfg,
   input  logic                 fire,
   input  sofs_pkg::item_type   item,
   output sofs_pkg::result_type result
);
   import sofs_pkg::*;

   localparam int CMP_W = (AGE_WIDTH > TIME_W) ? AGE_WIDTH : TIME_W;

   logic [TORQUE_W-1:0]  base_a_ff, base_a_in;
   logic [TORQUE_W-1:0]  base_b_ff, base_b_in;
   logic                 active_ff, active_in;
   logic [AGE_WIDTH-1:0] spike_age_ff, spike_age_in;
   logic [AGE_WIDTH-1:0] hb_age_ff, hb_age_in;
   logic [AGE_WIDTH-1:0] st_age_ff, st_age_in;
   logic [FAULT_W-1:0]   fault_ff, fault_in;

   logic [TORQUE_W-1:0]  diff_a, diff_b;
   logic                 spike;
   logic                 hb_trip, st_trip;

   always_comb begin
      diff_a = (item.torque_a >= base_a_ff) ? item.torque_a - base_a_ff
                                            : base_a_ff - item.torque_a;
      diff_b = (item.torque_b >= base_b_ff) ? item.torque_b - base_b_ff
                                            : base_b_ff - item.torque_b;
      spike = (diff_a > cfg.spike_threshold) || (diff_b > cfg.spike_threshold);

      base_a_in = base_a_ff;
      base_b_in = base_b_ff;
      active_in = active_ff;
      spike_age_in = spike_age_ff;
      hb_age_in = hb_age_ff;
      st_age_in = st_age_ff;
      fault_in = fault_ff;

      unique case (item.kind)
         KIND_TICK: begin
            hb_age_in = (&hb_age_ff) ? hb_age_ff : hb_age_ff + 1'b1;
            st_age_in = (&st_age_ff) ? st_age_ff : st_age_ff + 1'b1;
            if (active_ff) begin
               spike_age_in = (&spike_age_ff) ? spike_age_ff : spike_age_ff + 1'b1;
            end
         end
         KIND_TORQUE: begin
            if (spike) begin
               if (!active_ff) begin
                  active_in = 1'b1;
                  spike_age_in = '0;
               end else if ((CMP_W'(spike_age_ff) > CMP_W'(cfg.persist_time)) &&
                            (fault_ff == '0) && (item.requested_mode == MODE_ACTIVE)) begin
                  fault_in[FLT_OVERRIDE] = 1'b1;
               end
            end else begin
               active_in = 1'b0;
               spike_age_in = '0;
               if ((fault_ff == '0) && (item.requested_mode == MODE_DISENGAGED)) begin
                  base_a_in = item.torque_a;
                  base_b_in = item.torque_b;
               end
            end
         end
         KIND_STATUS: begin
            st_age_in = '0;
            if (item.unit_code != '0) begin
               fault_in[FLT_UNIT] = 1'b1;
            end
         end
         KIND_HEARTBEAT: begin
            hb_age_in = '0;
         end
         default: begin
            hb_age_in = hb_age_ff;
         end
      endcase

      // watchdogs see the faults left by the frame, then by the heartbeat check
      hb_trip = (CMP_W'(hb_age_in) > CMP_W'(cfg.heartbeat_timeout)) &&
                ((fault_in != '0) || (item.requested_mode != MODE_DISENGAGED));
      if (hb_trip) begin
         fault_in[FLT_HEARTBEAT] = 1'b1;
      end
      st_trip = (CMP_W'(st_age_in) > CMP_W'(cfg.status_timeout)) &&
                ((fault_in != '0) || (item.requested_mode != MODE_DISENGAGED));
      if (st_trip) begin
         fault_in[FLT_STATUS] = 1'b1;
      end

      result.fault_mask = fault_in;
      result.spike_pending = active_in;
      if (fault_in != '0) begin
         result.mode = MODE_FAULT;
      end else if (item.requested_mode == MODE_FAULT) begin
         result.mode = MODE_ARMED;
      end else begin
         result.mode = item.requested_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_a_ff <= BASELINE_RESET;
         base_b_ff <= BASELINE_RESET;
         active_ff <= 1'b0;
         spike_age_ff <= '0;
         hb_age_ff <= '0;
         st_age_ff <= '0;
         fault_ff <= '0;
      end else if (fire) begin
         base_a_ff <= base_a_in;
         base_b_ff <= base_b_in;
         active_ff <= active_in;
         spike_age_ff <= spike_age_in;
         hb_age_ff <= hb_age_in;
         st_age_ff <= st_age_in;
         fault_ff <= fault_in;
      end
   end

   `SOFS_ASSERT_NEXT(a_fault_sticky, !$past(reset),
                     (fault_ff & $past(fault_ff)) == $past(fault_ff))
   `SOFS_ASSERT_NOW(a_idle_age_zero, !active_ff, spike_age_ff == '0)
   `SOFS_ASSERT_NEXT(a_hold_no_fire, !fire, $stable(fault_ff) && $stable(active_ff))

endmodule

/* sv/steering_override_fault_supervisor_unit.sv */
// Steering override and fault supervisor. Each item on the req_ stream (tick, torque
// frame, status frame or host heartbeat) gives exactly one result on the rsp_ stream
// with the effective mode, the latched fault flags and the spike timing flag. One item
// is taken per clock cycle while rsp_tready stays high. Each accepted item waits in the
// input register while the single-pass compare and count logic feeds the result
// register, whose load makes the result valid. Two items can be held, and req_tready
// drops only while both registers are full and rsp_tready is low. Faults stay latched
// until reset. The csr_ port is always ready; the user must write it only while no
// item is in flight, as the block itself does not enforce this.
`include "steering_override_fault_supervisor_unit_macros.svh"

module steering_override_fault_supervisor_unit #(
   parameter int AGE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // torque_a [7:0], torque_b [15:8], unit_code [23:16], requested_mode [25:24]
   input  logic [sofs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // kind [1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // mode [1:0], fault_mask [5:2], spike_pending [6]
   output logic [sofs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sofs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sofs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sofs_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       fire;

   assign fire = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || fire;
   assign csr_ready = 1'b1;

   sofs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sofs_eval #(
      .AGE_WIDTH (AGE_WIDTH)
   ) u_eval (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.kind <= kind_type'(req_tuser);
         item_ff.torque_a <= req_tdata[7:0];
         item_ff.torque_b <= req_tdata[15:8];
         item_ff.unit_code <= req_tdata[23:16];
         item_ff.requested_mode <= req_tdata[25:24];
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, rsp_ff.spike_pending, rsp_ff.fault_mask, rsp_ff.mode};

   `SOFS_ASSERT_NOW(a_ready_when_empty, !rsp_valid_ff, req_tready)
   `SOFS_ASSERT_NOW(a_mode_fault_match, rsp_valid_ff,
                    (rsp_ff.mode == MODE_FAULT) == (rsp_ff.fault_mask != '0))
   `SOFS_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp_valid_ff)

endmodule
